// File: rtl/tls_pkg.sv
package tls_pkg;

    localparam logic [4:0] KIND_EOF   = 5'd0;
    localparam logic [4:0] KIND_AT    = 5'd1;
    localparam logic [4:0] KIND_CARET = 5'd2;
    localparam logic [4:0] KIND_AMP   = 5'd3;
    localparam logic [4:0] KIND_LPAR  = 5'd4;
    localparam logic [4:0] KIND_RPAR  = 5'd5;
    localparam logic [4:0] KIND_LBRK  = 5'd6;
    localparam logic [4:0] KIND_RBRK  = 5'd7;
    localparam logic [4:0] KIND_PIPE  = 5'd8;
    localparam logic [4:0] KIND_COLON = 5'd9;
    localparam logic [4:0] KIND_LT    = 5'd10;
    localparam logic [4:0] KIND_GT    = 5'd11;
    localparam logic [4:0] KIND_QUES  = 5'd12;
    localparam logic [4:0] KIND_TILDE = 5'd13;
    localparam logic [4:0] KIND_COMMA = 5'd14;
    localparam logic [4:0] KIND_REF   = 5'd15;
    localparam logic [4:0] KIND_STR   = 5'd16;
    localparam logic [4:0] KIND_NUM   = 5'd17;
    localparam logic [4:0] KIND_IDN   = 5'd18;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_INVALID = 2'd1;
    localparam logic [1:0] ERR_EOI     = 2'd2;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_BQUOTE = 8'h60;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_AT     = 8'h40;

    typedef enum logic [6:0] {
        MODE_IDLE    = 7'b0000001,
        MODE_COMMENT = 7'b0000010,
        MODE_REF     = 7'b0000100,
        MODE_STR     = 7'b0001000,
        MODE_NUM     = 7'b0010000,
        MODE_IDN     = 7'b0100000,
        MODE_HALTED  = 7'b1000000
    } mode_t;

    typedef struct packed {
        logic [4:0] kind;
        logic [7:0] value_char;
        logic       has_char;
        logic       token_begins;
        logic       token_ends;
        logic [1:0] error_code;
    } event_t;

    typedef struct packed {
        event_t ev0;
        event_t ev1;
        logic   two;
    } entry_t;

    typedef struct packed {
        event_t ev;
        logic   emit;
        mode_t  mode;
    } fresh_t;

    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        logic [4:0] k;
        begin
            case (c)
                CH_AT:  k = KIND_AT;
                8'h5E:  k = KIND_CARET;
                8'h26:  k = KIND_AMP;
                8'h28:  k = KIND_LPAR;
                8'h29:  k = KIND_RPAR;
                8'h5B:  k = KIND_LBRK;
                8'h5D:  k = KIND_RBRK;
                8'h7C:  k = KIND_PIPE;
                8'h3A:  k = KIND_COLON;
                8'h3C:  k = KIND_LT;
                8'h3E:  k = KIND_GT;
                8'h3F:  k = KIND_QUES;
                8'h7E:  k = KIND_TILDE;
                8'h2C:  k = KIND_COMMA;
                default: k = KIND_EOF;
            endcase
            return k;
        end
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic event_t mk_event(input logic [4:0] kind, input logic [7:0] ch,
                                        input logic has, input logic beg,
                                        input logic fin, input logic [1:0] err);
        event_t e;
        begin
            e.kind         = kind;
            e.value_char   = ch;
            e.has_char     = has;
            e.token_begins = beg;
            e.token_ends   = fin;
            e.error_code   = err;
            return e;
        end
    endfunction

endpackage

// File: rtl/tls_front.sv
module tls_front
    import tls_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] char_in,
    input  logic       end_of_input,
    output logic       push,
    output entry_t     entry
);

    mode_t mode_reg;
    mode_t mode_next;
    logic [1:0] n_ev;

    function automatic fresh_t scan_fresh(input logic [7:0] c);
        fresh_t f;
        logic [4:0] k;
        begin
            k = punct_kind(c);
            f.ev   = mk_event(KIND_EOF, 8'd0, 1'b0, 1'b0, 1'b0, ERR_NONE);
            f.emit = 1'b0;
            f.mode = MODE_IDLE;
            if (k != KIND_EOF) begin
                f.ev   = mk_event(k, 8'd0, 1'b0, 1'b1, 1'b1, ERR_NONE);
                f.emit = 1'b1;
            end
            else if (c == CH_SEMI) begin
                f.mode = MODE_COMMENT;
            end
            else if (c == CH_LBRACE) begin
                f.ev   = mk_event(KIND_REF, 8'd0, 1'b0, 1'b1, 1'b0, ERR_NONE);
                f.emit = 1'b1;
                f.mode = MODE_REF;
            end
            else if (c == CH_BQUOTE) begin
                f.ev   = mk_event(KIND_STR, 8'd0, 1'b0, 1'b1, 1'b0, ERR_NONE);
                f.emit = 1'b1;
                f.mode = MODE_STR;
            end
            else if (is_space(c)) begin
                f.mode = MODE_IDLE;
            end
            else if (is_digit(c) || (c == CH_DASH)) begin
                f.ev   = mk_event(KIND_NUM, c, 1'b1, 1'b1, 1'b0, ERR_NONE);
                f.emit = 1'b1;
                f.mode = MODE_NUM;
            end
            else if (is_alpha(c) || (c == CH_UNDER)) begin
                f.ev   = mk_event(KIND_IDN, c, 1'b1, 1'b1, 1'b0, ERR_NONE);
                f.emit = 1'b1;
                f.mode = MODE_IDN;
            end
            else begin
                f.ev   = mk_event(KIND_EOF, 8'd0, 1'b0, 1'b0, 1'b0, ERR_INVALID);
                f.emit = 1'b1;
                f.mode = MODE_HALTED;
            end
            return f;
        end
    endfunction

    always_comb
    begin
        fresh_t     f;
        logic [4:0] vkind;
        logic [4:0] qkind;
        logic [7:0] qclose;
        logic       fits;

        f         = scan_fresh(char_in);
        vkind     = (mode_reg == MODE_NUM) ? KIND_NUM : KIND_IDN;
        qkind     = (mode_reg == MODE_REF) ? KIND_REF : KIND_STR;
        qclose    = (mode_reg == MODE_REF) ? CH_RBRACE : CH_BQUOTE;
        fits      = (mode_reg == MODE_NUM)
                    ? (is_digit(char_in) || (char_in == CH_DOT))
                    : (is_alpha(char_in) || is_digit(char_in)
                       || (char_in == CH_UNDER) || (char_in == CH_DASH));
        entry.ev0 = mk_event(KIND_EOF, 8'd0, 1'b0, 1'b0, 1'b0, ERR_NONE);
        entry.ev1 = mk_event(KIND_EOF, 8'd0, 1'b0, 1'b0, 1'b0, ERR_NONE);
        n_ev      = 2'd0;
        mode_next = mode_reg;

        if (end_of_input) begin
            case (mode_reg)
                MODE_REF, MODE_STR:
                begin
                    entry.ev0 = mk_event(KIND_EOF, 8'd0, 1'b0, 1'b0, 1'b0, ERR_EOI);
                    n_ev      = 2'd1;
                    mode_next = MODE_HALTED;
                end
                MODE_NUM, MODE_IDN:
                begin
                    entry.ev0 = mk_event(vkind, 8'd0, 1'b0, 1'b0, 1'b1, ERR_NONE);
                    entry.ev1 = mk_event(KIND_EOF, 8'd0, 1'b0, 1'b1, 1'b1, ERR_NONE);
                    n_ev      = 2'd2;
                    mode_next = MODE_IDLE;
                end
                MODE_IDLE, MODE_COMMENT:
                begin
                    entry.ev0 = mk_event(KIND_EOF, 8'd0, 1'b0, 1'b1, 1'b1, ERR_NONE);
                    n_ev      = 2'd1;
                    mode_next = MODE_IDLE;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
        else begin
            case (mode_reg)
                MODE_COMMENT:
                begin
                    if (char_in == CH_LF)
                        mode_next = MODE_IDLE;
                end
                MODE_REF, MODE_STR:
                begin
                    n_ev = 2'd1;
                    if (char_in[7]) begin
                        entry.ev0 = mk_event(KIND_EOF, 8'd0, 1'b0, 1'b0, 1'b0, ERR_INVALID);
                        mode_next = MODE_HALTED;
                    end
                    else if (char_in == qclose) begin
                        entry.ev0 = mk_event(qkind, 8'd0, 1'b0, 1'b0, 1'b1, ERR_NONE);
                        mode_next = MODE_IDLE;
                    end
                    else begin
                        entry.ev0 = mk_event(qkind, char_in, 1'b1, 1'b0, 1'b0, ERR_NONE);
                    end
                end
                MODE_NUM, MODE_IDN:
                begin
                    if (fits) begin
                        entry.ev0 = mk_event(vkind, char_in, 1'b1, 1'b0, 1'b0, ERR_NONE);
                        n_ev      = 2'd1;
                    end
                    else begin
                        entry.ev0 = mk_event(vkind, 8'd0, 1'b0, 1'b0, 1'b1, ERR_NONE);
                        entry.ev1 = f.ev;
                        n_ev      = f.emit ? 2'd2 : 2'd1;
                        mode_next = f.mode;
                    end
                end
                MODE_IDLE:
                begin
                    entry.ev0 = f.ev;
                    n_ev      = {1'b0, f.emit};
                    mode_next = f.mode;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end

        entry.two = n_ev[1];
    end

    assign push      = accept && (n_ev != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_IDLE;
        else if (accept)
            mode_reg <= mode_next;
    end

endmodule

// File: rtl/tls_queue.sv
module tls_queue
    import tls_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   empty,
    output entry_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    entry_t        mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

endmodule

// File: rtl/tls_back.sv
module tls_back
    import tls_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       empty,
    input  entry_t     head,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [4:0] kind,
    output logic [7:0] value_char,
    output logic       has_char,
    output logic       token_begins,
    output logic       token_ends,
    output logic [1:0] error_code,
    output logic       last_result
);

    logic   out_valid_reg;
    logic   sel_reg;
    logic   sel_next;
    logic   load;
    logic   is_last;
    event_t cur;
    event_t ev_reg;
    logic   last_reg;

    assign load     = !empty && (!out_valid_reg || out_ready);
    assign is_last  = !head.two || sel_reg;
    assign cur      = sel_reg ? head.ev1 : head.ev0;
    assign pop      = load && is_last;
    assign sel_next = load ? !is_last : sel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else
        begin
            sel_reg <= sel_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ev_reg   <= cur;
            last_reg <= is_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = ev_reg.kind;
    assign value_char   = ev_reg.value_char;
    assign has_char     = ev_reg.has_char;
    assign token_begins = ev_reg.token_begins;
    assign token_ends   = ev_reg.token_ends;
    assign error_code   = ev_reg.error_code;
    assign last_result  = last_reg;

endmodule

// File: rtl/token_lexer_stream_core.sv
// Channel  Handshake            Payload
// -------  -------------------  ------------------------------------------------
// in       in_valid/in_ready    char_in[7:0], end_of_input
// out      out_valid/out_ready  kind[4:0], value_char[7:0], has_char, token_begins,
//                               token_ends, error_code[1:0], last_result
//
// One input transaction per cycle while in_ready is high; the scan mode register updates in the accept cycle.
// Each transaction yields 0, 1 or 2 output transactions, 1 per cycle from the back end while out_ready is high.
// Front and back are split by a QUEUE_DEPTH-entry queue; in_ready drops only when full.
// Output is registered; an accepted input is written to the queue, then loaded into the output register.
// Reset clears mode, queue pointers and output valid; a halted scanner needs reset.
module token_lexer_stream_core
    import tls_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_in,
    input  logic       end_of_input,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [4:0] kind,
    output logic [7:0] value_char,
    output logic       has_char,
    output logic       token_begins,
    output logic       token_ends,
    output logic [1:0] error_code,
    output logic       last_result
);

    logic   accept;
    logic   push;
    logic   full;
    logic   pop;
    logic   empty;
    entry_t entry;
    entry_t head;

    assign in_ready = !full;
    assign accept   = in_valid && !full;

    tls_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .char_in      (char_in),
        .end_of_input (end_of_input),
        .push         (push),
        .entry        (entry)
    );

    tls_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (entry),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    tls_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .value_char   (value_char),
        .has_char     (has_char),
        .token_begins (token_begins),
        .token_ends   (token_ends),
        .error_code   (error_code),
        .last_result  (last_result)
    );

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench
    import tls_pkg::*;
();

    typedef struct packed {
        logic [4:0] kind;
        logic [7:0] value_char;
        logic       has_char;
        logic       token_begins;
        logic       token_ends;
        logic [1:0] error_code;
        logic       last_result;
    } lex_tok_t;

    typedef struct packed {
        lex_tok_t   t0;
        lex_tok_t   t1;
        logic [1:0] cnt;
        mode_t      nxt;
    } lex_res_t;

    typedef struct packed {
        logic [7:0] c;
        logic       eoi;
        logic       drain;
    } src_item_t;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 300;
    localparam int LONG_HOLD_AT   = 400;
    localparam int RAND_ITEMS     = 1950;
    localparam int TAIL_CYCLES    = 10;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] char_in = 8'h00;
    logic       end_of_input = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [4:0] kind;
    logic [7:0] value_char;
    logic       has_char;
    logic       token_begins;
    logic       token_ends;
    logic [1:0] error_code;
    logic       last_result;

    src_item_t src_q[$];
    lex_tok_t  token_q[$];
    mode_t     gen_mode = MODE_IDLE;
    mode_t     shadow_mode = MODE_IDLE;
    string     fault_name = "none";

    int n_err = 0;
    int n_in = 0;
    int n_out = 0;
    int n_double = 0;
    int in_gap = 0;
    int tx_calm = 0;
    int rx_hold = 0;
    int rx_calm = 0;
    int idle_cycles = 0;
    bit long_done = 1'b0;

    token_lexer_stream_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_in      (char_in),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .value_char   (value_char),
        .has_char     (has_char),
        .token_begins (token_begins),
        .token_ends   (token_ends),
        .error_code   (error_code),
        .last_result  (last_result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [4:0] punct_code(input logic [7:0] c);
        case (c)
            CH_AT:   return KIND_AT;
            "^":     return KIND_CARET;
            "&":     return KIND_AMP;
            "(":     return KIND_LPAR;
            ")":     return KIND_RPAR;
            "[":     return KIND_LBRK;
            "]":     return KIND_RBRK;
            "|":     return KIND_PIPE;
            ":":     return KIND_COLON;
            "<":     return KIND_LT;
            ">":     return KIND_GT;
            "?":     return KIND_QUES;
            "~":     return KIND_TILDE;
            ",":     return KIND_COMMA;
            default: return KIND_EOF;
        endcase
    endfunction

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic lex_res_t add_tok(input lex_res_t r, input logic [4:0] k,
                                         input logic [7:0] ch, input logic has,
                                         input logic beg, input logic fin,
                                         input logic [1:0] err);
        lex_tok_t t;
        t.kind         = k;
        t.value_char   = ch;
        t.has_char     = has;
        t.token_begins = beg;
        t.token_ends   = fin;
        t.error_code   = err;
        t.last_result  = 1'b0;
        if (r.cnt == 2'd0)
            r.t0 = t;
        else
            r.t1 = t;
        r.cnt = r.cnt + 2'd1;
        return r;
    endfunction

    function automatic lex_res_t scan_fresh(input lex_res_t r, input logic [7:0] c);
        logic [4:0] k;
        k = punct_code(c);
        if (k != KIND_EOF)
        begin
            r = add_tok(r, k, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
            r.nxt = MODE_IDLE;
        end
        else if (c == CH_SEMI)
            r.nxt = MODE_COMMENT;
        else if (c == CH_LBRACE)
        begin
            r = add_tok(r, KIND_REF, 8'h00, 1'b0, 1'b1, 1'b0, ERR_NONE);
            r.nxt = MODE_REF;
        end
        else if (c == CH_BQUOTE)
        begin
            r = add_tok(r, KIND_STR, 8'h00, 1'b0, 1'b1, 1'b0, ERR_NONE);
            r.nxt = MODE_STR;
        end
        else if (is_blank(c))
            r.nxt = MODE_IDLE;
        else if (is_dec(c) || (c == CH_DASH))
        begin
            r = add_tok(r, KIND_NUM, c, 1'b1, 1'b1, 1'b0, ERR_NONE);
            r.nxt = MODE_NUM;
        end
        else if (is_letter(c) || (c == CH_UNDER))
        begin
            r = add_tok(r, KIND_IDN, c, 1'b1, 1'b1, 1'b0, ERR_NONE);
            r.nxt = MODE_IDN;
        end
        else
        begin
            r = add_tok(r, KIND_EOF, 8'h00, 1'b0, 1'b0, 1'b0, ERR_INVALID);
            r.nxt = MODE_HALTED;
        end
        return r;
    endfunction

    function automatic lex_res_t scan_step(input mode_t m, input logic [7:0] c,
                                           input logic eoi);
        lex_res_t   r;
        logic [4:0] vk;
        logic [7:0] close;
        logic       fits;
        r = '0;
        r.nxt = m;
        if (m == MODE_HALTED)
            return r;
        vk = (m == MODE_REF) ? KIND_REF : (m == MODE_STR) ? KIND_STR :
             (m == MODE_NUM) ? KIND_NUM : KIND_IDN;
        if (eoi)
        begin
            if ((m == MODE_REF) || (m == MODE_STR))
            begin
                r = add_tok(r, KIND_EOF, 8'h00, 1'b0, 1'b0, 1'b0, ERR_EOI);
                r.nxt = MODE_HALTED;
            end
            else
            begin
                if ((m == MODE_NUM) || (m == MODE_IDN))
                    r = add_tok(r, vk, 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE);
                r = add_tok(r, KIND_EOF, 8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
                r.nxt = MODE_IDLE;
            end
        end
        else
        begin
            case (m)
                MODE_COMMENT:
                begin
                    if (c == CH_LF)
                        r.nxt = MODE_IDLE;
                end
                MODE_REF, MODE_STR:
                begin
                    close = (m == MODE_REF) ? CH_RBRACE : CH_BQUOTE;
                    if (c[7])
                    begin
                        r = add_tok(r, KIND_EOF, 8'h00, 1'b0, 1'b0, 1'b0, ERR_INVALID);
                        r.nxt = MODE_HALTED;
                    end
                    else if (c == close)
                    begin
                        r = add_tok(r, vk, 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE);
                        r.nxt = MODE_IDLE;
                    end
                    else
                        r = add_tok(r, vk, c, 1'b1, 1'b0, 1'b0, ERR_NONE);
                end
                MODE_NUM, MODE_IDN:
                begin
                    if (m == MODE_NUM)
                        fits = is_dec(c) || (c == CH_DOT);
                    else
                        fits = is_letter(c) || is_dec(c) || (c == CH_UNDER) || (c == CH_DASH);
                    if (fits)
                        r = add_tok(r, vk, c, 1'b1, 1'b0, 1'b0, ERR_NONE);
                    else
                    begin
                        r = add_tok(r, vk, 8'h00, 1'b0, 1'b0, 1'b1, ERR_NONE);
                        r.nxt = MODE_IDLE;
                        r = scan_fresh(r, c);
                    end
                end
                default:
                    r = scan_fresh(r, c);
            endcase
        end
        if (r.cnt == 2'd1)
            r.t0.last_result = 1'b1;
        else if (r.cnt == 2'd2)
            r.t1.last_result = 1'b1;
        return r;
    endfunction

    // stimulus generation; push_item drops anything that would halt the scanner
    task automatic push_raw(input logic [7:0] c, input logic eoi);
        lex_res_t  r;
        src_item_t it;
        r = scan_step(gen_mode, c, eoi);
        gen_mode = r.nxt;
        it.c = c;
        it.eoi = eoi;
        it.drain = 1'b0;
        src_q.push_back(it);
    endtask

    task automatic push_item(input logic [7:0] c, input logic eoi);
        lex_res_t r;
        r = scan_step(gen_mode, c, eoi);
        if (r.nxt != MODE_HALTED)
            push_raw(c, eoi);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_item(s[i], 1'b0);
    endtask

    task automatic gen_token();
        string      punct_set = "@^&()[]|:<>?~,";
        string      idn_set = "abzAZ09_-qM";
        int         sel;
        int         len;
        logic [7:0] open;
        logic [7:0] close;
        logic [7:0] c;
        sel = $urandom_range(0, 99);
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 5);
        if (sel < 20)
            push_item(punct_set[$urandom_range(0, 13)], 1'b0);
        else if (sel < 30)
            push_item(($urandom_range(0, 3) == 0) ? CH_SPACE : 8'($urandom_range(9, 13)), 1'b0);
        else if (sel < 38)
        begin
            push_item(CH_SEMI, 1'b0);
            repeat (len) push_item(8'($urandom), 1'b0);
            if ($urandom_range(0, 5) != 0)
                push_item(CH_LF, 1'b0);
        end
        else if (sel < 62)
        begin
            open = (sel < 50) ? CH_LBRACE : CH_BQUOTE;
            close = (sel < 50) ? CH_RBRACE : CH_BQUOTE;
            push_item(open, 1'b0);
            repeat (len)
            begin
                c = 8'($urandom_range(0, 127));
                if (c == close)
                    c = "q";
                push_item(c, 1'b0);
            end
            if ($urandom_range(0, 7) != 0)
                push_item(close, 1'b0);
        end
        else if (sel < 77)
        begin
            push_item(($urandom_range(0, 3) == 0) ? CH_DASH : 8'("0" + $urandom_range(0, 9)),
                      1'b0);
            repeat (len)
                push_item(($urandom_range(0, 3) == 0) ? CH_DOT : 8'("0" + $urandom_range(0, 9)),
                          1'b0);
        end
        else if (sel < 92)
        begin
            case ($urandom_range(0, 2))
                0: push_item(CH_UNDER, 1'b0);
                1: push_item(8'("a" + $urandom_range(0, 25)), 1'b0);
                default: push_item(8'("A" + $urandom_range(0, 25)), 1'b0);
            endcase
            repeat (len) push_item(idn_set[$urandom_range(0, idn_set.len() - 1)], 1'b0);
        end
        else if (sel < 95)
            push_item(8'($urandom), 1'b1);
        else
            push_item(8'($urandom), 1'b0);
    endtask

    // the scanner halts until reset, so exactly one fault ends the stream
    task automatic push_fault();
        lex_res_t   r;
        logic [7:0] c;
        logic [7:0] open;
        case (gen_mode)
            MODE_REF:     push_item(CH_RBRACE, 1'b0);
            MODE_STR:     push_item(CH_BQUOTE, 1'b0);
            MODE_COMMENT: push_item(CH_LF, 1'b0);
            default:      ;
        endcase
        push_item(CH_SPACE, 1'b0);
        open = ($urandom_range(0, 1) == 0) ? CH_LBRACE : CH_BQUOTE;
        case ($urandom_range(0, 4))
            0:
            begin
                fault_name = "invalid low byte";
                do
                begin
                    c = 8'($urandom_range(0, 127));
                    r = scan_step(MODE_IDLE, c, 1'b0);
                end
                while (r.nxt != MODE_HALTED);
                push_raw(c, 1'b0);
            end
            1:
            begin
                fault_name = "high byte while idle";
                push_raw(8'($urandom_range(128, 255)), 1'b0);
            end
            2:
            begin
                fault_name = "high byte in quoted token";
                push_item(open, 1'b0);
                push_item("k", 1'b0);
                push_raw(8'($urandom_range(128, 255)), 1'b0);
            end
            3:
            begin
                fault_name = "high byte ending num or idn";
                push_item(($urandom_range(0, 1) == 0) ? 8'("7") : 8'("q"), 1'b0);
                push_raw(8'($urandom_range(128, 255)), 1'b0);
            end
            default:
            begin
                fault_name = "end of input in quoted token";
                push_item(open, 1'b0);
                push_raw(8'($urandom), 1'b1);
            end
        endcase
        repeat (4) push_raw(8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_err++;
        end
    endtask

    function automatic int draw_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65)
            return 0;
        if (p < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // driver
    always @(posedge clk)
    begin
        lex_res_t  r;
        src_item_t it;
        logic      offer;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            offer = in_valid;
            if (in_valid && in_ready)
            begin
                r = scan_step(shadow_mode, char_in, end_of_input);
                shadow_mode = r.nxt;
                if (r.cnt != 2'd0)
                    token_q.push_back(r.t0);
                if (r.cnt == 2'd2)
                begin
                    token_q.push_back(r.t1);
                    n_double++;
                end
                n_in++;
                offer = 1'b0;
            end
            if (!offer)
            begin
                if (in_gap > 0)
                    in_gap--;
                else if ((src_q.size() > 0) && !(src_q[0].drain && (token_q.size() != 0)))
                begin
                    it = src_q.pop_front();
                    char_in <= it.c;
                    end_of_input <= it.eoi;
                    offer = 1'b1;
                    if (tx_calm > 0)
                    begin
                        tx_calm--;
                        in_gap = 0;
                    end
                    else
                    begin
                        in_gap = draw_gap();
                        if ($urandom_range(0, 149) == 0)
                            tx_calm = $urandom_range(30, 80);
                    end
                end
            end
            in_valid <= offer;
        end
    end

    // receiver backpressure
    always @(posedge clk)
    begin
        int p;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (!long_done && (n_out >= LONG_HOLD_AT))
            begin
                long_done = 1'b1;
                rx_hold = LONG_HOLD;
            end
            if (rx_hold > 0)
            begin
                rx_hold--;
                out_ready <= 1'b0;
            end
            else if (rx_calm > 0)
            begin
                rx_calm--;
                out_ready <= 1'b1;
            end
            else
            begin
                p = $urandom_range(0, 99);
                if (p < 70)
                    out_ready <= 1'b1;
                else
                begin
                    out_ready <= 1'b0;
                    rx_hold = (p < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                end
                if ($urandom_range(0, 199) == 0)
                    rx_calm = $urandom_range(30, 100);
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        lex_tok_t want;
        if (rst_n && out_valid && out_ready)
        begin
            n_out++;
            if (token_q.size() == 0)
            begin
                $error("unexpected transaction: kind %0d value_char %0d error_code %0d",
                       kind, value_char, error_code);
                n_err++;
            end
            else
            begin
                want = token_q.pop_front();
                check_field("kind", want.kind, kind);
                check_field("value_char", want.value_char, value_char);
                check_field("has_char", want.has_char, has_char);
                check_field("token_begins", want.token_begins, token_begins);
                check_field("token_ends", want.token_ends, token_ends);
                check_field("error_code", want.error_code, error_code);
                check_field("last_result", want.last_result, last_result);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int n_dir;
        push_text("@^&()[]|:<>?~,{x}");
        push_item(CH_BQUOTE, 1'b0);
        push_item("y", 1'b0);
        push_item(CH_BQUOTE, 1'b0);
        push_text("-1.;");
        push_item(8'hFF, 1'b0);
        push_item(CH_LF, 1'b0);
        push_text("_a9");
        push_item(8'hFF, 1'b1);
        push_item(8'h00, 1'b1);
        n_dir = src_q.size();
        while (src_q.size() < n_dir + RAND_ITEMS)
            gen_token();
        src_q[n_dir + RAND_ITEMS / 2].drain = 1'b1;
        push_fault();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while ((src_q.size() != 0) || in_valid || (token_q.size() != 0))
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("lexer run: %0d input and %0d output transactions, %0d inputs gave two tokens",
                 n_in, n_out, n_double);
        $display("stream closed by fault case: %s", fault_name);
        if (n_err == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: token_lexer_stream_core.f
rtl/tls_pkg.sv
rtl/tls_front.sv
rtl/tls_queue.sv
rtl/tls_back.sv
rtl/token_lexer_stream_core.sv
tb/sv/testbench.sv
